// ===== rtl/core/gwm_pkg.sv =====
`timescale 1ns / 1ps

package gwm_pkg;

    localparam int MAX_PATTERN = 32;
    // one cell per pattern position plus the end-of-pattern position
    localparam int NUM_CELLS   = MAX_PATTERN + 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    localparam logic [7:0] CH_STAR     = 8'd42;
    localparam logic [7:0] CH_QUESTION = 8'd63;

    typedef enum logic [1:0] {
        REQ_PATTERN = 2'd0,
        REQ_SUBJECT = 2'd1,
        REQ_QUERY   = 2'd2
    } req_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             wr_en;
        logic [LEN_W-1:0] wr_idx;
        logic [7:0]       ch;
        logic             restart;
        logic             advance;
        logic [LEN_W-1:0] len;
    } cell_ctl_t;

endpackage

// ===== rtl/core/gwm_cell.sv =====
`timescale 1ns / 1ps

module gwm_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [gwm_pkg::LEN_W-1:0] cell_idx,
    input  gwm_pkg::cell_ctl_t       ctl,
    input  logic                     pass_star_in,
    input  logic                     adv_in,
    input  logic                     nstar_in,
    input  logic                     qstar_in,
    output logic                     pass_star_out,
    output logic                     adv_out,
    output logic                     nstar_out,
    output logic                     qstar_out,
    output logic                     end_hit,
    output logic                     query_hit
);
    import gwm_pkg::*;

    logic [7:0] char_reg;
    logic       act_reg;
    logic       act_next;
    logic       in_pat;
    logic       is_end;
    logic       is_star;
    logic       ch_ok;
    logic       cur;
    logic       nxt;
    logic       is_first;

    assign in_pat   = cell_idx < ctl.len;
    assign is_end   = cell_idx == ctl.len;
    assign is_first = cell_idx == '0;
    assign is_star  = in_pat && (char_reg == CH_STAR);
    assign ch_ok    = in_pat && ((char_reg == CH_QUESTION) || (char_reg == ctl.ch));

    // stored pattern never has two stars in a row, so closure is one hop
    assign cur           = act_reg | pass_star_in;
    assign pass_star_out = act_reg & is_star;
    assign adv_out       = cur & ch_ok;
    assign nxt           = (cur & is_star) | adv_in;
    assign nstar_out     = nxt & is_star;
    assign end_hit       = (nxt | nstar_in) & is_end;

    // empty subject: closure of the start set
    assign qstar_out = is_first & is_star;
    assign query_hit = (is_first | qstar_in) & is_end;

    always_comb begin
        act_next = act_reg;
        if (ctl.restart) begin
            act_next = is_first;
        end else if (ctl.advance) begin
            act_next = nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= is_first;
        end else begin
            act_reg <= act_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en && (ctl.wr_idx == cell_idx)) begin
            char_reg <= ctl.ch;
        end
    end

endmodule

// ===== rtl/core/glob_wildcard_matcher.sv =====
`timescale 1ns / 1ps

// Glob matcher: a subject byte string is checked against a stored pattern in which
// '*' matches any run of bytes (also none) and '?' matches any one byte. Pattern
// bytes (tuser = 0) load the pattern, the first byte of a run replacing the old one
// and tlast closing it; runs of stars are stored as one star. Subject bytes
// (tuser = 1) each advance a row of cells, one per pattern position plus one for
// the end position, each holding its pattern byte and an active bit; tlast on the
// subject gives one result. tuser = 2 asks for the empty subject and gives one
// result at once; tuser = 3 is dropped. A pattern of more than MAX_PATTERN bytes
// is flagged and every result then reports no match and pattern_too_long.
// The active set updates through the cell row as each subject byte is taken, and an
// item is taken in every cycle that the output register is free or being drained, so
// a result appears in the cycle after its last subject byte.
module glob_wildcard_matcher (
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_value[7:0]
    input  logic [1:0] s_tuser,   // req_type[1:0]
    input  logic       s_tlast,   // is_last
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // match_found[0], pattern_too_long[1], zero[7:2]
);
    import gwm_pkg::*;

    logic             s_xfer;
    req_t             req;

    // pattern store control
    logic [LEN_W-1:0] len_reg,   len_next;
    logic [LEN_W-1:0] raw_reg,   raw_next;
    logic             ovf_reg,   ovf_next;
    logic             load_reg,  load_next;
    logic             lstar_reg, lstar_next;

    // result register
    logic             mvalid_reg, mvalid_next;
    logic             match_reg,  match_next;
    logic             long_reg,   long_next;

    cell_ctl_t        ctl;

    // neighbor links through the cell row
    logic [NUM_CELLS:0] pass_star;
    logic [NUM_CELLS:0] adv;
    logic [NUM_CELLS:0] nstar;
    logic [NUM_CELLS:0] qstar;
    logic [NUM_CELLS-1:0] end_hit;
    logic [NUM_CELLS-1:0] query_hit;

    assign s_tready = !mvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign req      = req_t'(s_tuser);

    assign pass_star[0] = 1'b0;
    assign adv[0]       = 1'b0;
    assign nstar[0]     = 1'b0;
    assign qstar[0]     = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
            gwm_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .cell_idx      (LEN_W'(gi)),
                .ctl           (ctl),
                .pass_star_in  (pass_star[gi]),
                .adv_in        (adv[gi]),
                .nstar_in      (nstar[gi]),
                .qstar_in      (qstar[gi]),
                .pass_star_out (pass_star[gi+1]),
                .adv_out       (adv[gi+1]),
                .nstar_out     (nstar[gi+1]),
                .qstar_out     (qstar[gi+1]),
                .end_hit       (end_hit[gi]),
                .query_hit     (query_hit[gi])
            );
        end
    endgenerate

    always_comb begin
        logic [LEN_W-1:0] base_len;
        logic [LEN_W-1:0] base_raw;
        logic             base_lstar;
        logic             ch_star;

        base_len   = load_reg ? len_reg : '0;
        base_raw   = load_reg ? raw_reg : '0;
        base_lstar = load_reg && lstar_reg;
        ch_star    = s_tdata == CH_STAR;

        len_next    = len_reg;
        raw_next    = raw_reg;
        ovf_next    = ovf_reg;
        load_next   = load_reg;
        lstar_next  = lstar_reg;
        mvalid_next = mvalid_reg && !m_tready;
        match_next  = match_reg;
        long_next   = long_reg;

        ctl.wr_en   = 1'b0;
        ctl.wr_idx  = base_len;
        ctl.ch      = s_tdata;
        ctl.restart = 1'b0;
        ctl.advance = 1'b0;
        ctl.len     = len_reg;

        if (s_xfer) begin
            case (req)
                REQ_PATTERN: begin
                    ctl.restart = 1'b1;
                    load_next   = !s_tlast;
                    len_next    = base_len;
                    raw_next    = base_raw;
                    lstar_next  = base_lstar;
                    ovf_next    = load_reg && ovf_reg;
                    if (base_raw < LEN_W'(MAX_PATTERN)) begin
                        raw_next = base_raw + 1'b1;
                        // a star right after a star adds nothing
                        if (!(ch_star && base_lstar)) begin
                            ctl.wr_en  = 1'b1;
                            len_next   = base_len + 1'b1;
                            lstar_next = ch_star;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                REQ_SUBJECT: begin
                    load_next = 1'b0;
                    if (s_tlast) begin
                        ctl.restart = 1'b1;
                        mvalid_next = 1'b1;
                        match_next  = !ovf_reg && (|end_hit);
                        long_next   = ovf_reg;
                    end else begin
                        ctl.advance = 1'b1;
                    end
                end
                REQ_QUERY: begin
                    load_next   = 1'b0;
                    ctl.restart = 1'b1;
                    mvalid_next = 1'b1;
                    match_next  = !ovf_reg && (|query_hit);
                    long_next   = ovf_reg;
                end
                default: begin
                    // unused request type: no effect
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            raw_reg    <= '0;
            ovf_reg    <= 1'b0;
            load_reg   <= 1'b0;
            lstar_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            len_reg    <= len_next;
            raw_reg    <= raw_next;
            ovf_reg    <= ovf_next;
            load_reg   <= load_next;
            lstar_reg  <= lstar_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        match_reg <= match_next;
        long_reg  <= long_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {6'b0, long_reg, match_reg};

endmodule

// ===== rtl/core/gwm_checker.sv =====
`timescale 1ns / 1ps

module gwm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import gwm_pkg::*;

    // a held result stays until taken
    a_mvalid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    // a new result needs an input transfer just before
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without an input transfer");

    // a pattern byte never produces a result
    a_pattern_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_PATTERN) && (!m_tvalid || m_tready)
        |=> !m_tvalid)
        else $error("result after a pattern byte");

    // an overflowed pattern never matches
    a_long_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("match reported with overflowed pattern");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_glob_wildcard_matcher.sv =====
`timescale 1ns / 1ps

module tb_glob_wildcard_matcher;

    import gwm_pkg::*;

    // the block drops this request code without a result
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;   // char_value[7:0]
    logic [1:0] s_tuser  = 2'd0;   // req_type[1:0]
    logic       s_tlast  = 1'b0;   // is_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // match_found[0], pattern_too_long[1], zero[7:2]

    glob_wildcard_matcher i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // one expected verdict per subject string or empty-subject query
    typedef struct packed {
        logic too_long;
        logic match;
    } verdict_t;

    verdict_t verdicts_q[$];

    // shadow of the matcher state: stored pattern, length, active positions
    logic [7:0]           pat_mem [MAX_PATTERN];
    int unsigned          pat_len  = 0;
    logic [MAX_PATTERN:0] live_pos = 1;
    bit                   pat_ovf  = 1'b0;
    bit                   pat_open = 1'b0;

    // stimulus scratch: the pattern last generated and the run being sent
    logic [7:0] pat_gen[$];
    logic [7:0] run_buf[$];

    bit idle_on = 1'b1;
    int n_errors    = 0;
    int n_sent      = 0;
    int n_results   = 0;
    int n_patterns  = 0;
    int n_exp_match = 0;
    int n_exp_ovf   = 0;
    verdict_t got_v;

    // a star position that is live also makes the position after it live;
    // ascending order lets runs of stars chain through in one pass
    function automatic logic [MAX_PATTERN:0] star_closure(logic [MAX_PATTERN:0] act);
        for (int i = 0; i < pat_len; i++) begin
            if (act[i] && pat_mem[i] == CH_STAR) act[i+1] = 1'b1;
        end
        return act;
    endfunction

    function automatic void push_verdict(logic end_live);
        verdict_t v;
        v.match    = !pat_ovf && end_live;
        v.too_long = pat_ovf;
        if (v.match) n_exp_match++;
        if (v.too_long) n_exp_ovf++;
        verdicts_q.push_back(v);
    endfunction

    // advance the shadow state by one accepted transfer, queue any verdict
    function automatic void match_step(logic [1:0] req, logic [7:0] ch, logic last);
        logic [MAX_PATTERN:0] cur;
        logic [MAX_PATTERN:0] nxt;
        if (req == REQ_UNUSED) return;
        if (req == REQ_PATTERN) begin
            // first byte of a new pattern wipes length and overflow flag
            if (!pat_open) begin
                pat_len = 0;
                pat_ovf = 1'b0;
            end
            if (pat_len < MAX_PATTERN) begin
                pat_mem[pat_len] = ch;
                pat_len++;
            end else begin
                pat_ovf = 1'b1;
            end
            pat_open = !last;
            live_pos = 1;
            return;
        end
        // a subject byte or a query closes a half-loaded pattern
        pat_open = 1'b0;
        if (req == REQ_QUERY) begin
            live_pos = 1;
            cur = star_closure(live_pos);
            push_verdict(cur[pat_len]);
            return;
        end
        cur = star_closure(live_pos);
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
            if (cur[i]) begin
                if (pat_mem[i] == CH_STAR) nxt[i] = 1'b1;
                if (pat_mem[i] == CH_QUESTION || pat_mem[i] == ch) nxt[i+1] = 1'b1;
            end
        end
        if (last) begin
            nxt = star_closure(nxt);
            push_verdict(nxt[pat_len]);
            live_pos = 1;
        end else begin
            live_pos = nxt;
        end
    endfunction

    // result side: random backpressure, changed on the falling edge
    always @(negedge aclk) begin
        m_tready <= !(idle_on && $urandom_range(99) < 36);
    end

    // every result transfer is checked against the oldest queued verdict
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (verdicts_q.size() == 0) begin
                $error("result transfer with no verdict pending, tdata=%h", m_tdata);
                n_errors++;
            end else begin
                got_v = verdicts_q.pop_front();
                if (m_tdata[0] !== got_v.match) begin
                    $error("match_found: expected %0b, got %0b", got_v.match, m_tdata[0]);
                    n_errors++;
                end
                if (m_tdata[1] !== got_v.too_long) begin
                    $error("pattern_too_long: expected %0b, got %0b",
                           got_v.too_long, m_tdata[1]);
                    n_errors++;
                end
            end
        end
    end

    // one input transfer: optional idle gap, then hold until accepted
    task automatic send_byte(logic [1:0] req, logic [7:0] ch, logic last);
        @(negedge aclk);
        while (idle_on && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        match_step(req, ch, last);
        if (req != REQ_UNUSED) n_sent++;
    endtask

    // send run_buf; tlast on the final byte only when the run is closed
    task automatic send_buf(logic [1:0] req, bit close);
        foreach (run_buf[i]) send_byte(req, run_buf[i], close && i == run_buf.size() - 1);
    endtask

    task automatic send_str(logic [1:0] req, string s);
        run_buf.delete();
        for (int i = 0; i < s.len(); i++) run_buf.push_back(s[i]);
        send_buf(req, 1'b1);
    endtask

    // stop sending until every verdict is back, then a short settle
    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (verdicts_q.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_letter();
        return 8'h61 + 8'($urandom_range(1));
    endfunction

    // mostly short patterns heavy in wildcards, now and then one past the store
    task automatic make_pattern();
        int len;
        int pick;
        pat_gen.delete();
        len = ($urandom_range(19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
        repeat (len) begin
            pick = $urandom_range(9);
            if (pick < 3) pat_gen.push_back(CH_STAR);
            else if (pick < 5) pat_gen.push_back(CH_QUESTION);
            else if (pick < 9) pat_gen.push_back(pick_letter());
            else pat_gen.push_back(8'($urandom));
        end
        run_buf = pat_gen;
        n_patterns++;
    endtask

    // follow=1 builds a subject from the pattern (likely match), sometimes
    // with one byte spoiled; otherwise a short random string
    task automatic make_subject(bit follow);
        run_buf.delete();
        if (follow) begin
            foreach (pat_gen[i]) begin
                if (pat_gen[i] == CH_STAR)
                    repeat ($urandom_range(3)) run_buf.push_back(pick_letter());
                else if (pat_gen[i] == CH_QUESTION)
                    run_buf.push_back(8'($urandom));
                else
                    run_buf.push_back(pat_gen[i]);
            end
            if (run_buf.size() > 0 && $urandom_range(4) == 0)
                run_buf[$urandom_range(run_buf.size() - 1)] = pick_letter();
        end else begin
            repeat ($urandom_range(8))
                run_buf.push_back(($urandom_range(3) == 0) ? 8'($urandom) : pick_letter());
        end
    endtask

    // a pattern, then a few subjects; some noise and cut-short runs mixed in
    task automatic run_session();
        int pick;
        make_pattern();
        // about one pattern in ten is left open and closed by what follows
        send_buf(REQ_PATTERN, $urandom_range(9) != 0);
        repeat ($urandom_range(1, 4)) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_byte(REQ_UNUSED, 8'($urandom), 1'($urandom));
            end else if (pick < 14) begin
                send_byte(REQ_QUERY, 8'($urandom), 1'($urandom));
            end else begin
                make_subject(pick < 65);
                if (run_buf.size() == 0) begin
                    send_byte(REQ_QUERY, 8'($urandom), 1'($urandom));
                end else if (pick >= 90) begin
                    // subject abandoned halfway by an empty-subject query
                    send_buf(REQ_SUBJECT, 1'b0);
                    send_byte(REQ_QUERY, 8'($urandom), 1'($urandom));
                end else begin
                    send_buf(REQ_SUBJECT, 1'b1);
                end
            end
        end
    endtask

    // after reset the pattern is empty: only the empty subject matches
    task automatic test_empty_pattern();
        send_byte(REQ_QUERY, 8'h00, 1'b1);
        send_str(REQ_SUBJECT, "a");
    endtask

    task automatic test_wildcards();
        send_str(REQ_PATTERN, "a*?c");
        send_str(REQ_SUBJECT, "abxc");
        send_str(REQ_SUBJECT, "ac");
        send_byte(REQ_QUERY, 8'hff, 1'b0);
    endtask

    // all-zero and all-one bytes as literal pattern and subject bytes
    task automatic test_extreme_bytes();
        run_buf = '{8'h00, 8'hff};
        send_buf(REQ_PATTERN, 1'b1);
        send_buf(REQ_SUBJECT, 1'b1);
    endtask

    task automatic test_unused_request();
        send_byte(REQ_UNUSED, 8'h5a, 1'b1);
        send_byte(REQ_UNUSED, 8'ha5, 1'b0);
    endtask

    // a lone star, never closed with tlast; the query ends the load
    task automatic test_subject_during_load();
        send_byte(REQ_PATTERN, CH_STAR, 1'b0);
        send_byte(REQ_QUERY, 8'h00, 1'b1);
    endtask

    task automatic test_query_mid_subject();
        send_byte(REQ_SUBJECT, 8'h78, 1'b0);
        send_byte(REQ_QUERY, 8'h00, 1'b0);
    endtask

    // one byte past the store sets the flag; a fresh pattern clears it
    task automatic test_pattern_overflow();
        run_buf.delete();
        repeat (MAX_PATTERN + 1) run_buf.push_back(CH_STAR);
        send_buf(REQ_PATTERN, 1'b1);
        send_byte(REQ_QUERY, 8'h00, 1'b1);
        send_str(REQ_SUBJECT, "q");
        send_str(REQ_PATTERN, "b");
        send_str(REQ_SUBJECT, "b");
    endtask

    task automatic test_random_traffic(int count, bit with_idle);
        int stop_at;
        int sessions;
        stop_at  = n_sent + count;
        sessions = 0;
        idle_on  = with_idle;
        while (n_sent < stop_at) begin
            run_session();
            sessions++;
            // every so often the sender holds off until all verdicts are back
            if (sessions % 12 == 1) wait_results_drained();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_pattern();
        test_wildcards();
        test_extreme_bytes();
        test_unused_request();
        test_subject_during_load();
        test_query_mid_subject();
        test_pattern_overflow();
        test_random_traffic(180, 1'b1);
        // long stretch with both sides streaming flat out
        test_random_traffic(120, 1'b0);
        test_random_traffic(180, 1'b1);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (verdicts_q.size() == 0);
        repeat (10) @(posedge aclk);

        $display("%0d input transfers over %0d random patterns, %0d results checked",
                 n_sent, n_patterns, n_results);
        $display("%0d of them expected to match, %0d flagged as pattern overflow",
                 n_exp_match, n_exp_ovf);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #400_000;
        $display("timeout with %0d verdicts still pending", verdicts_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
